[hw/rtl/udp_receive_checker_unit_defines.svh]
// assertion macros for the udp receive checker
`ifndef UDP_RECEIVE_CHECKER_UNIT_DEFINES_SVH
`define UDP_RECEIVE_CHECKER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define URC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("urc assertion failed");
`define URC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("urc assertion failed");
`else
`define URC_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define URC_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/urc_pkg.sv]
package urc_pkg;

  localparam int MAX_BYTES  = 2048;
  localparam int PORT_SLOTS = 4;
  localparam int CNT_W      = $clog2(MAX_BYTES + 1);
  localparam int HDR_BYTES  = 8;
  localparam int SUM_W      = 20;
  localparam logic [15:0] UDP_PROTO = 16'h0011;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [2:0]       cfg_idx_t;
  typedef logic [1:0]       slot_idx_t;
  typedef logic [PORT_SLOTS-1:0][15:0] slot_ports_t;

  localparam cfg_idx_t CFG_LOCAL_IP    = 3'd0;
  localparam cfg_idx_t CFG_PORT_SLOT_0 = 3'd1;
  localparam cfg_idx_t CFG_SLOT_ENABLE = 3'd5;

  typedef enum logic [2:0] {
    VERDICT_DELIVER   = 3'd0,
    VERDICT_TOO_SHORT = 3'd1,
    VERDICT_BAD_LEN   = 3'd2,
    VERDICT_BAD_CSUM  = 3'd3,
    VERDICT_NO_PORT   = 3'd4
  } verdict_t;

  // finished segment handed to the verdict stage
  typedef struct packed {
    logic        too_long;
    cnt_t        len;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] hdr_len;
    logic [15:0] hdr_csum;
    logic [15:0] word_sum;
    logic [7:0]  held;
    logic [16:0] sip_sum;
  } seg_rec_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] payload_len;
    slot_idx_t   slot;
  } result_t;

endpackage

[hw/rtl/urc_verdict.sv]
module urc_verdict (
  input  urc_pkg::seg_rec_t    rec,
  input  logic [17:0]          lip_sum,
  input  urc_pkg::slot_ports_t port_slot,
  input  logic [urc_pkg::PORT_SLOTS-1:0] slot_enable,
  output urc_pkg::result_t     res
);

  logic [urc_pkg::SUM_W-1:0] wide_sum;
  logic [16:0]               fold1;
  logic [15:0]               fold2;
  logic [15:0]               odd_word;
  logic                      csum_ok;
  logic                      port_hit;
  urc_pkg::slot_idx_t        hit_slot;

  assign odd_word = rec.len[0] ? {rec.held, 8'h00} : 16'h0000;

  // pseudo-header and data words in one wide add, then end-around carry
  assign wide_sum = urc_pkg::SUM_W'(rec.word_sum) + urc_pkg::SUM_W'(odd_word)
                  + urc_pkg::SUM_W'(rec.sip_sum) + urc_pkg::SUM_W'(lip_sum)
                  + urc_pkg::SUM_W'(rec.len);
  assign fold1 = 17'(wide_sum[15:0]) + 17'(wide_sum[urc_pkg::SUM_W-1:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);
  assign csum_ok = (~fold2) == rec.hdr_csum;

  // lowest open slot wins
  always_comb begin
    port_hit = 1'b0;
    hit_slot = '0;
    for (int i = urc_pkg::PORT_SLOTS - 1; i >= 0; i--) begin
      if (slot_enable[i] && (port_slot[i] == rec.dport)) begin
        port_hit = 1'b1;
        hit_slot = urc_pkg::slot_idx_t'(i);
      end
    end
  end

  always_comb begin
    res.sport       = rec.sport;
    res.dport       = rec.dport;
    res.payload_len = 16'h0000;
    res.slot        = '0;
    if (rec.too_long) begin
      res.verdict = urc_pkg::VERDICT_BAD_LEN;
    end else if (rec.len < urc_pkg::cnt_t'(urc_pkg::HDR_BYTES)) begin
      res.verdict = urc_pkg::VERDICT_TOO_SHORT;
    end else begin
      res.payload_len = 16'(rec.len) - 16'(urc_pkg::HDR_BYTES);
      if (rec.hdr_len > 16'(rec.len)) begin
        res.verdict = urc_pkg::VERDICT_BAD_LEN;
      end else if (!csum_ok) begin
        res.verdict = urc_pkg::VERDICT_BAD_CSUM;
      end else if (port_hit) begin
        res.verdict = urc_pkg::VERDICT_DELIVER;
        res.slot    = hit_slot;
      end else begin
        res.verdict = urc_pkg::VERDICT_NO_PORT;
      end
    end
  end

endmodule

[hw/rtl/udp_receive_checker_unit.sv]
// udp receive checker
// in_*: one segment byte per request, header first; in_tlast marks the final
// byte, and the sender address in in_tdata is taken from that final byte.
// out_*: one verdict per segment, with the header ports, payload length and
// the matched port slot (zero unless delivered).
// cfg_*: register writes, index 0 local address, 1 to 4 port slots, 5 slot
// enables; write only while no segment is in flight.
// throughput: one byte per cycle except while a last byte waits as described below;
// segments may follow each other with no gap; the per-byte header capture
// and running sum use a 16-bit one's-complement add with end-around carry.
// the verdict passes the input, segment record and output registers in order.
// a waiting verdict does not hold up the bytes of the next segment; only its
// last byte waits while both the record stage and the output are full.
// reset clears the segment state, the port slots and slot enables and every valid
// flag, and the block is ready for bytes as soon as reset is released.
`include "udp_receive_checker_unit_defines.svh"

module udp_receive_checker_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // data_byte[7:0], sender_ip[39:8]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // verdict[2:0], source_port[18:3], dest_port[34:19], payload_length[50:35],
  // matched_slot[52:51], zero[55:53]
  output logic [55:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // configuration
  logic [17:0]                    lip_sum_r;
  urc_pkg::slot_ports_t           port_slot_r;
  logic [urc_pkg::PORT_SLOTS-1:0] slot_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lip_sum_r     <= 18'(urc_pkg::UDP_PROTO);
      port_slot_r   <= '0;
      slot_enable_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == urc_pkg::CFG_LOCAL_IP) begin
        lip_sum_r <= 18'(cfg_wdata[31:16]) + 18'(cfg_wdata[15:0])
                   + 18'(urc_pkg::UDP_PROTO);
      end
      for (int i = 0; i < urc_pkg::PORT_SLOTS; i++) begin
        if (cfg_index == urc_pkg::cfg_idx_t'(int'(urc_pkg::CFG_PORT_SLOT_0) + i)) begin
          port_slot_r[i] <= cfg_wdata[15:0];
        end
      end
      if (cfg_index == urc_pkg::CFG_SLOT_ENABLE) begin
        slot_enable_r <= cfg_wdata[urc_pkg::PORT_SLOTS-1:0];
      end
    end
  end

  // handshake
  logic a_valid_r, a_last_r;
  logic [7:0]  a_byte_r;
  logic [16:0] a_sip_sum_r;
  logic c_valid_r, out_valid_r;
  urc_pkg::seg_rec_t c_rec_r;
  urc_pkg::result_t  out_res_r, res;
  logic out_load, c_free, b_go, seg_end, in_accept;

  assign out_load  = c_valid_r && (!out_valid_r || out_tready);
  assign c_free    = !c_valid_r || out_load;
  assign b_go      = a_valid_r && (!a_last_r || c_free);
  assign seg_end   = b_go && a_last_r;
  assign in_tready = !a_valid_r || b_go;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= in_accept ? 1'b1 : (b_go ? 1'b0 : a_valid_r);
      c_valid_r   <= seg_end ? 1'b1 : (out_load ? 1'b0 : c_valid_r);
      out_valid_r <= out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_byte_r    <= in_tdata[7:0];
      a_last_r    <= in_tlast;
      a_sip_sum_r <= 17'(in_tdata[39:24]) + 17'(in_tdata[23:8]);
    end
  end

  // per-segment state
  urc_pkg::cnt_t byte_count_r, byte_count_upd, byte_count_nxt;
  logic [15:0] word_sum_r, word_sum_upd, word_sum_nxt;
  logic [7:0]  held_r, held_upd, held_nxt;
  logic [15:0] src_r, src_upd, src_nxt;
  logic [15:0] dst_r, dst_upd, dst_nxt;
  logic [15:0] hlen_r, hlen_upd, hlen_nxt;
  logic [15:0] csum_r, csum_upd, csum_nxt;
  logic        too_long_r, too_long_upd, too_long_nxt;
  urc_pkg::cnt_t pos;
  logic        ignore;

  assign pos    = byte_count_r;
  assign ignore = too_long_r || (pos >= urc_pkg::cnt_t'(urc_pkg::MAX_BYTES));

  always_comb begin
    byte_count_upd = byte_count_r;
    word_sum_upd   = word_sum_r;
    held_upd       = held_r;
    src_upd        = src_r;
    dst_upd        = dst_r;
    hlen_upd       = hlen_r;
    csum_upd       = csum_r;
    too_long_upd   = too_long_r;
    if (ignore) begin
      too_long_upd = 1'b1;
    end else begin
      case (pos)
        urc_pkg::cnt_t'(0): src_upd  = {a_byte_r, 8'h00};
        urc_pkg::cnt_t'(1): src_upd  = {src_r[15:8], a_byte_r};
        urc_pkg::cnt_t'(2): dst_upd  = {a_byte_r, 8'h00};
        urc_pkg::cnt_t'(3): dst_upd  = {dst_r[15:8], a_byte_r};
        urc_pkg::cnt_t'(4): hlen_upd = {a_byte_r, 8'h00};
        urc_pkg::cnt_t'(5): hlen_upd = {hlen_r[15:8], a_byte_r};
        urc_pkg::cnt_t'(6): csum_upd = {a_byte_r, 8'h00};
        urc_pkg::cnt_t'(7): csum_upd = {csum_r[15:8], a_byte_r};
        default: ;
      endcase
      // checksum field words count as zero
      if (!pos[0]) begin
        held_upd = (pos == urc_pkg::cnt_t'(6)) ? 8'h00 : a_byte_r;
      end else if (pos != urc_pkg::cnt_t'(7)) begin
        word_sum_upd = oc_add(word_sum_r, {held_r, a_byte_r});
      end
      byte_count_upd = pos + urc_pkg::cnt_t'(1);
    end
  end

  always_comb begin
    byte_count_nxt = byte_count_r;
    word_sum_nxt   = word_sum_r;
    held_nxt       = held_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    hlen_nxt       = hlen_r;
    csum_nxt       = csum_r;
    too_long_nxt   = too_long_r;
    if (seg_end) begin
      byte_count_nxt = '0;
      word_sum_nxt   = '0;
      held_nxt       = '0;
      src_nxt        = '0;
      dst_nxt        = '0;
      hlen_nxt       = '0;
      csum_nxt       = '0;
      too_long_nxt   = 1'b0;
    end else if (b_go) begin
      byte_count_nxt = byte_count_upd;
      word_sum_nxt   = word_sum_upd;
      held_nxt       = held_upd;
      src_nxt        = src_upd;
      dst_nxt        = dst_upd;
      hlen_nxt       = hlen_upd;
      csum_nxt       = csum_upd;
      too_long_nxt   = too_long_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      word_sum_r   <= '0;
      held_r       <= '0;
      src_r        <= '0;
      dst_r        <= '0;
      hlen_r       <= '0;
      csum_r       <= '0;
      too_long_r   <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      word_sum_r   <= word_sum_nxt;
      held_r       <= held_nxt;
      src_r        <= src_nxt;
      dst_r        <= dst_nxt;
      hlen_r       <= hlen_nxt;
      csum_r       <= csum_nxt;
      too_long_r   <= too_long_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (seg_end) begin
      c_rec_r.too_long <= too_long_upd;
      c_rec_r.len      <= byte_count_upd;
      c_rec_r.sport    <= src_upd;
      c_rec_r.dport    <= dst_upd;
      c_rec_r.hdr_len  <= hlen_upd;
      c_rec_r.hdr_csum <= csum_upd;
      c_rec_r.word_sum <= word_sum_upd;
      c_rec_r.held     <= held_upd;
      c_rec_r.sip_sum  <= a_sip_sum_r;
    end
  end

  urc_verdict u_verdict (
    .rec         (c_rec_r),
    .lip_sum     (lip_sum_r),
    .port_slot   (port_slot_r),
    .slot_enable (slot_enable_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.slot, out_res_r.payload_len, out_res_r.dport,
                       out_res_r.sport, out_res_r.verdict};

  `URC_ASSERT_IMP(a_cnt_cap, clk, rst_n, 1'b1,
    byte_count_r <= urc_pkg::cnt_t'(urc_pkg::MAX_BYTES))
  `URC_ASSERT_IMP(a_too_long_cnt, clk, rst_n, too_long_r,
    byte_count_r == urc_pkg::cnt_t'(urc_pkg::MAX_BYTES))
  `URC_ASSERT_NXT(a_seg_rec, clk, rst_n, seg_end, c_valid_r && (byte_count_r == '0))
  `URC_ASSERT_IMP(a_slot_zero, clk, rst_n,
    out_valid_r && (out_res_r.verdict != urc_pkg::VERDICT_DELIVER), out_res_r.slot == '0)
  `URC_ASSERT_IMP(a_stall_src, clk, rst_n, !in_tready, a_valid_r && a_last_r && c_valid_r)

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BYTES = 550;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_index  = '0;
  logic [31:0] cfg_wdata  = '0;

  udp_receive_checker_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // register copies
  logic [31:0] cfg_ip;
  logic [15:0] cfg_port [urc_pkg::PORT_SLOTS];
  logic [3:0]  cfg_slot_en;

  // segment being received
  int          seg_count;
  logic [15:0] seg_sum;
  logic [7:0]  seg_held;
  logic [15:0] seg_sport;
  logic [15:0] seg_dport;
  logic [15:0] seg_hdr_len;
  logic [15:0] seg_hdr_csum;
  logic        seg_overflow;

  urc_pkg::result_t pending_verdicts [$];
  logic [7:0]       seg_bytes [$];

  int error_count;
  int cycle_count;
  int bytes_sent;
  int segments_sent;
  int results_checked;
  int random_bytes;
  int random_segments;
  int verdict_tally [5];
  int hold_left;
  int stall_left;
  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  task automatic clear_segment_state();
    seg_count    = 0;
    seg_sum      = '0;
    seg_held     = '0;
    seg_sport    = '0;
    seg_dport    = '0;
    seg_hdr_len  = '0;
    seg_hdr_csum = '0;
    seg_overflow = 1'b0;
  endtask

  task automatic predict_segment_byte(input logic [7:0] b, input logic [31:0] sip,
                                      input logic last);
    int               pos;
    int               len;
    logic [15:0]      s;
    urc_pkg::result_t r;
    pos = seg_count;
    if (seg_overflow || pos >= urc_pkg::MAX_BYTES) begin
      seg_overflow = 1'b1;
    end else begin
      case (pos)
        0: seg_sport = {b, 8'h00};
        1: seg_sport[7:0] = b;
        2: seg_dport = {b, 8'h00};
        3: seg_dport[7:0] = b;
        4: seg_hdr_len = {b, 8'h00};
        5: seg_hdr_len[7:0] = b;
        6: seg_hdr_csum = {b, 8'h00};
        7: seg_hdr_csum[7:0] = b;
        default: ;
      endcase
      if (pos % 2 == 0) begin
        seg_held = (pos == 6) ? 8'h00 : b;
      end else if (pos != 7) begin
        seg_sum = ones_add(seg_sum, {seg_held, b});
      end
      seg_count = pos + 1;
    end
    if (!last) return;

    len         = seg_count;
    r.verdict   = urc_pkg::VERDICT_DELIVER;
    r.sport     = seg_sport;
    r.dport     = seg_dport;
    r.payload_len = '0;
    r.slot      = '0;
    if (seg_overflow) begin
      r.verdict = urc_pkg::VERDICT_BAD_LEN;
    end else if (len < urc_pkg::HDR_BYTES) begin
      r.verdict = urc_pkg::VERDICT_TOO_SHORT;
    end else begin
      r.payload_len = 16'(len - urc_pkg::HDR_BYTES);
      if (seg_hdr_len > len) begin
        r.verdict = urc_pkg::VERDICT_BAD_LEN;
      end else begin
        s = seg_sum;
        if (len % 2 == 1) s = ones_add(s, {seg_held, 8'h00});
        s = ones_add(s, sip[31:16]);
        s = ones_add(s, sip[15:0]);
        s = ones_add(s, cfg_ip[31:16]);
        s = ones_add(s, cfg_ip[15:0]);
        s = ones_add(s, urc_pkg::UDP_PROTO);
        s = ones_add(s, 16'(len));
        if (~s != seg_hdr_csum) begin
          r.verdict = urc_pkg::VERDICT_BAD_CSUM;
        end else begin
          r.verdict = urc_pkg::VERDICT_NO_PORT;
          // walk down so the lowest open match is the one kept
          for (int i = urc_pkg::PORT_SLOTS - 1; i >= 0; i--) begin
            if (cfg_slot_en[i] && cfg_port[i] == seg_dport) begin
              r.verdict = urc_pkg::VERDICT_DELIVER;
              r.slot    = urc_pkg::slot_idx_t'(i);
            end
          end
        end
      end
    end
    pending_verdicts.push_back(r);
    clear_segment_state();
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want_v);
    error_count++;
    if (error_count <= 40) begin
      $display("t=%0t request %0d: %s got 0x%0h expected 0x%0h",
               $time, results_checked, what, got, want_v);
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding",
               cycle_count, pending_verdicts.size());
      $display("udp_receive_checker_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    urc_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected verdict", 32'(out_tdata[2:0]), 32'hffff_ffff);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tdata[2:0] !== want.verdict)
          report_mismatch("verdict", 32'(out_tdata[2:0]), 32'(want.verdict));
        if (out_tdata[18:3] !== want.sport)
          report_mismatch("source_port", 32'(out_tdata[18:3]), 32'(want.sport));
        if (out_tdata[34:19] !== want.dport)
          report_mismatch("dest_port", 32'(out_tdata[34:19]), 32'(want.dport));
        if (out_tdata[50:35] !== want.payload_len)
          report_mismatch("payload_length", 32'(out_tdata[50:35]), 32'(want.payload_len));
        if (out_tdata[52:51] !== want.slot)
          report_mismatch("matched_slot", 32'(out_tdata[52:51]), 32'(want.slot));
        if (out_tdata[55:53] !== 3'b000)
          report_mismatch("padding", 32'(out_tdata[55:53]), 32'd0);
        verdict_tally[int'(want.verdict)]++;
      end
      results_checked++;
    end
  end

  // result side: random stalls, plus a long hold counted down here
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (receiver_idles && $urandom_range(0, 99) < 25) begin
      out_tready <= 1'b0;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                : $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int r;
    if (!sender_idles) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic [31:0] sip, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {sip, b};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_segment_byte(b, sip, last);
    bytes_sent++;
  endtask

  task automatic send_segment(input logic [31:0] sip);
    int n;
    n = seg_bytes.size();
    // sender address only counts on the final byte, noise elsewhere
    for (int i = 0; i < n; i++) begin
      send_byte(seg_bytes[i], (i == n - 1) ? sip : $urandom, i == n - 1);
    end
    segments_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input urc_pkg::cfg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      urc_pkg::CFG_LOCAL_IP:    cfg_ip      = val;
      urc_pkg::CFG_SLOT_ENABLE: cfg_slot_en = val[3:0];
      default:                  cfg_port[idx - urc_pkg::CFG_PORT_SLOT_0] = val[15:0];
    endcase
  endtask

  task automatic set_config(input logic [31:0] ip, input logic [15:0] p0, input logic [15:0] p1,
                            input logic [15:0] p2, input logic [15:0] p3, input logic [3:0] en);
    write_reg(urc_pkg::CFG_LOCAL_IP, ip);
    write_reg(urc_pkg::cfg_idx_t'(urc_pkg::CFG_PORT_SLOT_0 + 0), {16'd0, p0});
    write_reg(urc_pkg::cfg_idx_t'(urc_pkg::CFG_PORT_SLOT_0 + 1), {16'd0, p1});
    write_reg(urc_pkg::cfg_idx_t'(urc_pkg::CFG_PORT_SLOT_0 + 2), {16'd0, p2});
    write_reg(urc_pkg::cfg_idx_t'(urc_pkg::CFG_PORT_SLOT_0 + 3), {16'd0, p3});
    write_reg(urc_pkg::CFG_SLOT_ENABLE, {28'd0, en});
  endtask

  function automatic logic [15:0] segment_checksum(input logic [31:0] sip);
    logic [15:0] s;
    int          n;
    s = '0;
    n = seg_bytes.size();
    for (int i = 0; i < n; i += 2) begin
      if (i != 6) s = ones_add(s, {seg_bytes[i], (i + 1 < n) ? seg_bytes[i + 1] : 8'h00});
    end
    s = ones_add(s, sip[31:16]);
    s = ones_add(s, sip[15:0]);
    s = ones_add(s, cfg_ip[31:16]);
    s = ones_add(s, cfg_ip[15:0]);
    s = ones_add(s, urc_pkg::UDP_PROTO);
    s = ones_add(s, 16'(n));
    return ~s;
  endfunction

  task automatic fix_checksum(input logic [31:0] sip);
    logic [15:0] c;
    c = segment_checksum(sip);
    seg_bytes[6] = c[15:8];
    seg_bytes[7] = c[7:0];
  endtask

  task automatic set_hdr_length(input int len);
    seg_bytes[4] = 8'(len >> 8);
    seg_bytes[5] = 8'(len);
  endtask

  // well-formed segment with random payload
  task automatic build_segment(input logic [15:0] sport, input logic [15:0] dport,
                               input int plen, input logic [31:0] sip);
    seg_bytes.delete();
    seg_bytes.push_back(sport[15:8]);
    seg_bytes.push_back(sport[7:0]);
    seg_bytes.push_back(dport[15:8]);
    seg_bytes.push_back(dport[7:0]);
    seg_bytes.push_back(8'h00);
    seg_bytes.push_back(8'h00);
    seg_bytes.push_back(8'h00);
    seg_bytes.push_back(8'h00);
    repeat (plen) seg_bytes.push_back(8'($urandom));
    set_hdr_length(plen + urc_pkg::HDR_BYTES);
    fix_checksum(sip);
  endtask

  task automatic build_noise(input int n);
    seg_bytes.delete();
    repeat (n) seg_bytes.push_back(8'($urandom));
  endtask

  task automatic test_reset_state();
    // all registers still zero: nothing open
    build_segment(16'h0000, 16'h0000, 0, 32'h0000_0000);
    send_segment(32'h0000_0000);
    build_noise(1);
    send_segment(32'hffff_ffff);
    wait_for_results();
  endtask

  task automatic test_directed();
    logic [31:0] sip;
    logic [15:0] c;
    sip = 32'h0a00_0002;
    // slot 0 closed, slots 1 and 2 share a port
    set_config(32'hc0a8_0001, 16'h0035, 16'h1f90, 16'h1f90, 16'hffff, 4'b1110);

    build_segment(16'h1234, 16'h1f90, 4, sip);
    send_segment(sip);
    build_segment(16'h0001, 16'hffff, 5, sip);
    send_segment(sip);
    build_segment(16'h0002, 16'h0035, 3, sip);
    send_segment(sip);
    build_segment(16'h0003, 16'h1f90, 6, sip);
    seg_bytes[7] = seg_bytes[7] ^ 8'h01;
    send_segment(sip);

    // stored checksum zero that is also the correct one
    build_segment(16'h0004, 16'h1f90, 2, sip);
    seg_bytes[8] = 8'h00;
    seg_bytes[9] = 8'h00;
    c = segment_checksum(sip);
    seg_bytes[8] = c[15:8];
    seg_bytes[9] = c[7:0];
    seg_bytes[6] = 8'h00;
    seg_bytes[7] = 8'h00;
    send_segment(sip);
    // stored zero that is wrong
    build_segment(16'h0005, 16'h1f90, 3, sip);
    seg_bytes[6] = (segment_checksum(sip) == 16'h0000) ? 8'h01 : 8'h00;
    seg_bytes[7] = 8'h00;
    send_segment(sip);

    // header length beyond received, then shorter than received
    build_segment(16'h0006, 16'h1f90, 4, sip);
    set_hdr_length(13);
    send_segment(sip);
    build_segment(16'h0007, 16'h1f90, 4, sip);
    set_hdr_length(8);
    fix_checksum(sip);
    send_segment(sip);

    build_segment(16'h0008, 16'hffff, 0, sip);
    send_segment(sip);
    build_noise(7);
    send_segment(sip);
    build_segment(16'hffff, 16'hffff, 7, 32'hffff_ffff);
    for (int i = urc_pkg::HDR_BYTES; i < seg_bytes.size(); i++) seg_bytes[i] = 8'hff;
    fix_checksum(32'hffff_ffff);
    send_segment(32'hffff_ffff);

    // largest accepted size, then beyond it, then a normal one
    build_segment(16'h0009, 16'h1f90, urc_pkg::MAX_BYTES - urc_pkg::HDR_BYTES, sip);
    send_segment(sip);
    build_segment(16'h000a, 16'h1f90, urc_pkg::MAX_BYTES - urc_pkg::HDR_BYTES + 12, sip);
    send_segment(sip);
    build_segment(16'h000b, 16'h1f90, 1, sip);
    send_segment(sip);
    wait_for_results();
  endtask

  task automatic test_config_extremes();
    set_config(32'h0000_0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'b1111);
    build_segment(16'hffff, 16'h0000, 3, 32'h0000_0000);
    send_segment(32'h0000_0000);
    wait_for_results();

    set_config(32'hffff_ffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 4'b1000);
    build_segment(16'h0000, 16'hffff, 2, 32'hffff_ffff);
    send_segment(32'hffff_ffff);
    wait_for_results();

    write_reg(urc_pkg::CFG_SLOT_ENABLE, 32'h0000_0000);
    build_segment(16'h5555, 16'hffff, 1, 32'haaaa_5555);
    send_segment(32'haaaa_5555);
    wait_for_results();
  endtask

  task automatic test_output_backpressure();
    logic [31:0] sip;
    set_config(32'h0102_0304, 16'h0050, 16'h01bb, 16'h0016, 16'h1388, 4'b1111);
    sender_idles = 1'b0;
    @(posedge clk);
    hold_left = 300;
    for (int i = 0; i < 12; i++) begin
      sip = $urandom;
      build_segment(16'($urandom), cfg_port[i % urc_pkg::PORT_SLOTS],
                    $urandom_range(0, 2), sip);
      send_segment(sip);
    end
    wait_for_results();
    sender_idles = 1'b1;
  endtask

  task automatic randomise_config();
    logic [15:0] ports [urc_pkg::PORT_SLOTS];
    for (int i = 0; i < urc_pkg::PORT_SLOTS; i++) begin
      ports[i] = ($urandom_range(0, 3) == 0 && i > 0) ? ports[$urandom_range(0, i - 1)]
                                                       : 16'($urandom);
    end
    set_config($urandom, ports[0], ports[1], ports[2], ports[3],
               ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'b1111);
  endtask

  task automatic test_random_traffic();
    int          kind;
    int          plen;
    logic [31:0] sip;
    logic [15:0] dport;
    for (int phase = 0; phase < 3; phase++) begin
      randomise_config();
      sender_idles   = (phase != 1);
      receiver_idles = (phase != 1);
      while (random_bytes < (phase + 1) * RANDOM_BYTES / 3 ||
             random_segments < (phase + 1) * 14) begin
        kind  = $urandom_range(0, 99);
        sip   = $urandom;
        plen  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        dport = ($urandom_range(0, 4) != 0)
              ? cfg_port[$urandom_range(0, urc_pkg::PORT_SLOTS - 1)] : 16'($urandom);
        build_segment(16'($urandom), dport, plen, sip);
        if (kind < 65) begin
          // well-formed as built
        end else if (kind < 73) begin
          seg_bytes[6 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
        end else if (kind < 80) begin
          set_hdr_length(seg_bytes.size() + $urandom_range(1, 300));
        end else if (kind < 86) begin
          set_hdr_length($urandom_range(0, seg_bytes.size() - 1));
          fix_checksum(sip);
        end else if (kind < 92) begin
          build_noise($urandom_range(1, urc_pkg::HDR_BYTES - 1));
        end else begin
          build_noise($urandom_range(1, 24));
        end
        send_segment(sip);
        random_bytes += seg_bytes.size();
        random_segments++;
      end
      wait_for_results();
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  initial begin
    clear_segment_state();
    cfg_ip      = '0;
    cfg_slot_en = '0;
    for (int i = 0; i < urc_pkg::PORT_SLOTS; i++) cfg_port[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_directed();
    test_config_extremes();
    test_output_backpressure();
    test_random_traffic();
    wait_for_results();

    $display("sent %0d segments (%0d bytes) over several register settings, %0d verdicts checked",
             segments_sent, bytes_sent, results_checked);
    $display("deliver %0d, too short %0d, bad length %0d, checksum %0d, port closed %0d",
             verdict_tally[urc_pkg::VERDICT_DELIVER], verdict_tally[urc_pkg::VERDICT_TOO_SHORT],
             verdict_tally[urc_pkg::VERDICT_BAD_LEN], verdict_tally[urc_pkg::VERDICT_BAD_CSUM],
             verdict_tally[urc_pkg::VERDICT_NO_PORT]);
    if (error_count == 0 && pending_verdicts.size() == 0) begin
      $display("udp_receive_checker_unit verification clean");
    end else begin
      $display("udp_receive_checker_unit verification failed");
    end
    $finish;
  end

endmodule

[udp_receive_checker_unit.f]
+incdir+hw/rtl
hw/rtl/urc_pkg.sv
hw/rtl/urc_verdict.sv
hw/rtl/udp_receive_checker_unit.sv
dv/tb_top.sv
